// ===== sv/llhs_pkg.sv =====
// Shared constants, types and helper functions for the log-scale latency
// histogram block. No dependencies.
`default_nettype none

package llhs_pkg;

   localparam int BUCKETS       = 64;
   localparam int COUNTER_WIDTH = 32;

   localparam int BUCKET_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int DUR_W     = 64;
   localparam int SEL_W     = 6;
   localparam int OUT_CNT_W = 32;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 264;

   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

   localparam logic MODE_RECORD = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   typedef struct packed {
      logic [COUNTER_WIDTH-1:0] count;
      logic [DUR_W-1:0]         sum;
      logic [DUR_W-1:0]         min;
      logic [DUR_W-1:0]         max;
   } stats_type;

   // Smallest duration d with d * 5^k >= 100 * 7^k. Nested ceiling divisions
   // by five give the same result as one ceiling division by 5^k.
   function automatic logic [DUR_W-1:0] bucket_threshold(input int k);
      logic [255:0] n;
      n = 256'd100;
      for (int j = 0; j < k; j++) begin
         n = n * 256'd7;
      end
      for (int j = 0; j < k; j++) begin
         n = (n + 256'd4) / 256'd5;
      end
      return n[DUR_W-1:0];
   endfunction

   function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
      return (v == CNT_MAX) ? CNT_MAX : v + COUNTER_WIDTH'(1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/latency_log_histogram_stats_unit.sv =====
// Top level of the log-scale latency histogram with running statistics.
// Uses llhs_pkg, llhs_bucket_calc, llhs_stats and llhs_hist_mem.
`default_nettype none

// A request either records a timing sample (tuser mode 0) or reads one
// histogram bucket (mode 1); every request yields exactly one response, in
// order. The block takes one request per clock unless the output stalls. The
// subtract feeds the first register, then come the threshold compare, the
// bucket encode with the counter memory read, and finally the counter update
// with the output register. The histogram counters live in a memory with a
// registered read; back-to-back hits on the same bucket are forwarded, so no
// cycle is lost. The whole pipeline stalls only while a response waits and
// rsp_tready is low. Reset needs no clearing pass.
module latency_log_histogram_stats_unit
   import llhs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [63:0] start_time, [127:64] end_time, [133:128] bucket_select, rest zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] mode, [1] stamps_ok
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [5:0] sample_bucket, [37:6] total_samples, [101:38] duration_sum,
   // [165:102] duration_min, [229:166] duration_max, [261:230] bucket_value
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // [0] accepted
   output logic                       rsp_tuser
);

   logic                 advance;
   logic [DUR_W:0]       diff_ext;
   logic                 req_ok;
   logic                 req_sel_ok;
   logic [SEL_W-1:0]     req_sel;

   logic                 a_valid_ff, a_mode_ff, a_ok_ff, a_sel_ok_ff;
   logic [BUCKET_W-1:0]  a_sel_ff;
   logic [DUR_W-1:0]     a_dur_ff;

   logic                 b_valid_ff, b_mode_ff, b_ok_ff, b_sel_ok_ff;
   logic [BUCKET_W-1:0]  b_sel_ff;
   logic [BUCKET_W-1:0]  b_bucket;
   logic [BUCKET_W-1:0]  b_addr;

   logic                 c_valid_ff, c_mode_ff, c_ok_ff, c_sel_ok_ff;
   logic [BUCKET_W-1:0]  c_bucket_ff;
   stats_type            c_stats_ff;

   stats_type            stats;
   logic                 stats_update;
   logic                 c_record;
   logic [COUNTER_WIDTH-1:0] count;

   logic                 out_valid_ff;
   logic                 out_accepted_ff;
   logic [SEL_W-1:0]     out_bucket_ff;
   stats_type            out_stats_ff;
   logic [OUT_CNT_W-1:0] out_value_ff;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   assign diff_ext   = {1'b0, req_tdata[127:64]} - {1'b0, req_tdata[63:0]};
   assign req_ok     = req_tuser[1] && !diff_ext[DUR_W];
   assign req_sel    = req_tdata[133:128];
   assign req_sel_ok = (int'(req_sel) < BUCKETS);

   // Stage A: duration and validity.
   always_ff @(posedge clock) begin
      if (advance) begin
         a_mode_ff   <= req_tuser[0];
         a_ok_ff     <= req_ok;
         a_sel_ok_ff <= req_sel_ok;
         a_sel_ff    <= req_sel_ok ? req_sel[BUCKET_W-1:0] : '0;
         a_dur_ff    <= diff_ext[DUR_W-1:0];
      end
   end

   assign stats_update = advance && a_valid_ff && (a_mode_ff == MODE_RECORD) && a_ok_ff;

   llhs_stats u_stats (
      .clock  (clock),
      .reset  (reset),
      .update (stats_update),
      .dur    (a_dur_ff),
      .stats  (stats)
   );

   llhs_bucket_calc u_bucket (
      .clock   (clock),
      .advance (advance),
      .dur     (a_dur_ff),
      .bucket  (b_bucket)
   );

   // Stage B: thresholds compared; the counter read is issued here.
   always_ff @(posedge clock) begin
      if (advance) begin
         b_mode_ff   <= a_mode_ff;
         b_ok_ff     <= a_ok_ff;
         b_sel_ok_ff <= a_sel_ok_ff;
         b_sel_ff    <= a_sel_ff;
      end
   end

   assign b_addr = (b_mode_ff == MODE_RECORD) ? b_bucket : b_sel_ff;

   // Stage C: counter data available; statistics include this request here.
   always_ff @(posedge clock) begin
      if (advance) begin
         c_mode_ff   <= b_mode_ff;
         c_ok_ff     <= b_ok_ff;
         c_sel_ok_ff <= b_sel_ok_ff;
         c_bucket_ff <= b_bucket;
         c_stats_ff  <= stats;
      end
   end

   assign c_record = c_valid_ff && (c_mode_ff == MODE_RECORD) && c_ok_ff;

   llhs_hist_mem u_hist (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rd_addr   (b_addr),
      .increment (c_record),
      .count     (count)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         out_accepted_ff <= (c_mode_ff == MODE_RECORD) && c_ok_ff;
         out_bucket_ff   <= ((c_mode_ff == MODE_RECORD) && c_ok_ff) ?
                            SEL_W'(c_bucket_ff) : '0;
         out_stats_ff    <= c_stats_ff;
         out_value_ff    <= ((c_mode_ff == MODE_READ) && c_sel_ok_ff) ?
                            OUT_CNT_W'(count) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= req_tvalid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         out_valid_ff <= c_valid_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_accepted_ff;
   assign rsp_tdata  = {2'b00,
                        out_value_ff,
                        out_stats_ff.max,
                        out_stats_ff.min,
                        out_stats_ff.sum,
                        OUT_CNT_W'(out_stats_ff.count),
                        out_bucket_ff};

   // A counted sample always leaves a nonzero sample count behind it.
   a_count_after_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[37:6] != '0))
      else $error("counted sample with zero total");

   // Once any sample is counted, the minimum never exceeds the maximum.
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[37:6] != '0)) |-> (rsp_tdata[165:102] <= rsp_tdata[229:166]))
      else $error("minimum above maximum");

   // Accepted record responses never carry a bucket counter value.
   a_record_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[261:230] == '0))
      else $error("record response with bucket value");

endmodule

`default_nettype wire

// ===== sv/llhs_bucket_calc.sv =====
// Log bucket finder: compares a duration against every bucket threshold in
// parallel, registers the result and encodes the highest bucket. Uses llhs_pkg.
`default_nettype none

module llhs_bucket_calc
   import llhs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                advance,
   input  wire logic [DUR_W-1:0]    dur,
   output logic      [BUCKET_W-1:0] bucket
);

   logic [BUCKETS-1:0] therm_ff;
   logic [BUCKETS-1:0] therm_in;

   // Bit k is set when the duration reaches the threshold of bucket k.
   // Bit 0 is tied high since every accepted duration lands in bucket 0 or above.
   assign therm_in[0] = 1'b1;
   for (genvar k = 1; k < BUCKETS; k++) begin : g_cmp
      localparam logic [DUR_W-1:0] THRESH = bucket_threshold(k);
      assign therm_in[k] = (dur >= THRESH);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         therm_ff <= therm_in;
      end
   end

   always_comb begin
      bucket = '0;
      for (int k = 1; k < BUCKETS; k++) begin
         if (therm_ff[k] && therm_ff[0]) begin
            bucket = BUCKET_W'(k);
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/llhs_stats.sv =====
// Running count, sum, minimum and maximum of accepted durations.
// Uses llhs_pkg.
`default_nettype none

module llhs_stats
   import llhs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             update,
   input  wire logic [DUR_W-1:0] dur,
   output stats_type             stats
);

   stats_type stats_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff.count <= '0;
         stats_ff.sum   <= '0;
         stats_ff.min   <= '1;
         stats_ff.max   <= '0;
      end else if (update) begin
         stats_ff.count <= sat_inc(stats_ff.count);
         stats_ff.sum   <= stats_ff.sum + dur;
         if (dur < stats_ff.min) begin
            stats_ff.min <= dur;
         end
         if (dur > stats_ff.max) begin
            stats_ff.max <= dur;
         end
      end
   end

   assign stats = stats_ff;

endmodule

`default_nettype wire

// ===== sv/llhs_hist_mem.sv =====
// Histogram counter memory with a registered read, per-entry valid bits that
// reset clears, and read-modify-write with forwarding of the last write.
// Uses llhs_pkg.
`default_nettype none

module llhs_hist_mem
   import llhs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  wire logic [BUCKET_W-1:0]      rd_addr,
   input  wire logic                     increment,
   output logic      [COUNTER_WIDTH-1:0] count
);

   logic [COUNTER_WIDTH-1:0] mem [BUCKETS];
   logic [BUCKETS-1:0]       vbit_ff;
   logic [COUNTER_WIDTH-1:0] rd_data_ff;
   logic                     rd_vbit_ff;
   logic [BUCKET_W-1:0]      rd_addr_ff;
   logic                     lw_valid_ff;
   logic [BUCKET_W-1:0]      lw_addr_ff;
   logic [COUNTER_WIDTH-1:0] lw_data_ff;
   logic                     wr_en;
   logic [COUNTER_WIDTH-1:0] wr_data;

   // A read issued in the same cycle as a write to the same entry sees the
   // old data; the last write is held and forwarded in that case.
   always_comb begin
      if (lw_valid_ff && (lw_addr_ff == rd_addr_ff)) begin
         count = lw_data_ff;
      end else if (rd_vbit_ff) begin
         count = rd_data_ff;
      end else begin
         count = '0;
      end
   end

   assign wr_en   = advance && increment;
   assign wr_data = sat_inc(count);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr_ff] <= wr_data;
      end
      if (advance) begin
         rd_data_ff <= mem[rd_addr];
         rd_vbit_ff <= vbit_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr_en) begin
         lw_addr_ff <= rd_addr_ff;
         lw_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbit_ff     <= '0;
         lw_valid_ff <= 1'b0;
      end else if (wr_en) begin
         vbit_ff[rd_addr_ff] <= 1'b1;
         lw_valid_ff         <= 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== bench/latency_log_histogram_stats_unit_tb.sv =====
// Self-checking testbench for latency_log_histogram_stats_unit: a scoreboard
// class predicts every response, plain tasks drive the request stream.
// Depends on llhs_pkg and the block itself.
`timescale 1ns / 100ps

import llhs_pkg::*;

typedef struct {
   logic                 accepted;
   logic [BUCKET_W-1:0]  bucket;
   logic [OUT_CNT_W-1:0] total;
   logic [DUR_W-1:0]     sum;
   logic [DUR_W-1:0]     min;
   logic [DUR_W-1:0]     max;
   logic [OUT_CNT_W-1:0] value;
} hist_rsp_type;

class hist_scoreboard;
   stats_type                stats;
   logic [COUNTER_WIDTH-1:0] bucket_count [BUCKETS];
   hist_rsp_type             expected_rsp [$];
   logic [BUCKETS-1:0]       bucket_hit;
   int mismatches;
   int samples_counted;
   int samples_rejected;
   int reads;
   int responses_checked;

   function new();
      stats.count = '0;
      stats.sum   = '0;
      stats.min   = '1;
      stats.max   = '0;
      for (int i = 0; i < BUCKETS; i++) bucket_count[i] = '0;
      bucket_hit        = '0;
      mismatches        = 0;
      samples_counted   = 0;
      samples_rejected  = 0;
      reads             = 0;
      responses_checked = 0;
   endfunction

   // Largest k whose scaled compare d*5^k >= 100*7^k still holds; 256 bits
   // keep both sides exact up to the last bucket.
   function int duration_bucket(logic [DUR_W-1:0] d);
      logic [255:0] scaled_d;
      logic [255:0] scaled_base;
      int           b;
      bit           done;
      b = 0;
      done = 0;
      if (d < 64'd100) return 0;
      scaled_d    = {192'd0, d};
      scaled_base = 256'd100;
      for (int k = 1; k < BUCKETS; k++) begin
         if (!done) begin
            scaled_d    = scaled_d * 256'd5;
            scaled_base = scaled_base * 256'd7;
            if (scaled_d < scaled_base) done = 1;
            else b = k;
         end
      end
      return b;
   endfunction

   function logic [COUNTER_WIDTH-1:0] bump(logic [COUNTER_WIDTH-1:0] c);
      return (c == CNT_MAX) ? c : c + COUNTER_WIDTH'(1);
   endfunction

   function void note_request(logic mode, logic [DUR_W-1:0] t0, logic [DUR_W-1:0] t1,
                              logic ok, logic [SEL_W-1:0] sel);
      hist_rsp_type     want;
      logic [DUR_W-1:0] d;
      int               b;
      want.accepted = 1'b0;
      want.bucket   = '0;
      want.value    = '0;
      if (mode == MODE_RECORD) begin
         if (ok && t1 >= t0) begin
            d = t1 - t0;
            b = duration_bucket(d);
            want.accepted = 1'b1;
            want.bucket   = b[BUCKET_W-1:0];
            stats.count   = bump(stats.count);
            stats.sum     = stats.sum + d;
            if (d < stats.min) stats.min = d;
            if (d > stats.max) stats.max = d;
            bucket_count[b] = bump(bucket_count[b]);
            bucket_hit[b]   = 1'b1;
            samples_counted++;
         end else begin
            samples_rejected++;
         end
      end else begin
         reads++;
         if (sel < BUCKETS) want.value = bucket_count[sel][OUT_CNT_W-1:0];
      end
      want.total = stats.count[OUT_CNT_W-1:0];
      want.sum   = stats.sum;
      want.min   = stats.min;
      want.max   = stats.max;
      expected_rsp.insert(expected_rsp.size(), want);
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch in %s on response %0d: expected %h, got %h",
                     $time, name, responses_checked, want, got);
      end
   endfunction

   function void check_response(logic [RSP_DATA_W-1:0] data, logic accepted);
      hist_rsp_type want;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response with no request waiting, data %h", $time, data);
         return;
      end
      want = expected_rsp.pop_front();
      compare_field("accepted", 64'(want.accepted), 64'(accepted));
      compare_field("sample_bucket", 64'(want.bucket), 64'(data[5:0]));
      compare_field("total_samples", 64'(want.total), 64'(data[37:6]));
      compare_field("duration_sum", want.sum, data[101:38]);
      compare_field("duration_min", want.min, data[165:102]);
      compare_field("duration_max", want.max, data[229:166]);
      compare_field("bucket_value", 64'(want.value), 64'(data[261:230]));
      responses_checked++;
   endfunction

   function int pending();
      return expected_rsp.size();
   endfunction

   function int buckets_reached();
      int n;
      n = 0;
      for (int i = 0; i < BUCKETS; i++) if (bucket_hit[i]) n++;
      return n;
   endfunction
endclass

module latency_log_histogram_stats_unit_tb;

   localparam int STALL_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 200;
   localparam int PHASE_ITEMS   = 293;
   localparam logic [63:0] TMAX = 64'hFFFF_FFFF_FFFF_FFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [63:0] start_time, [127:64] end_time, [133:128] bucket_select, rest zero
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // [0] mode, [1] stamps_ok
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [5:0] sample_bucket, [37:6] total_samples, [101:38] duration_sum,
   // [165:102] duration_min, [229:166] duration_max, [261:230] bucket_value
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] accepted
   logic                  rsp_tuser;

   hist_scoreboard sb = new();
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_request  = 0;
   int  stall_cycles  = 0;
   int  holds_done    = 0;

   latency_log_histogram_stats_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both handshakes are sampled here with the values from before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser[0], req_tdata[63:0], req_tdata[127:64],
                            req_tuser[1], req_tdata[133:128]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles = stall_cycles + 1;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
               $time, STALL_LIMIT, sb.pending());
      $display("[latency_log_histogram_stats_unit] ERROR");
      $finish;
   end

   // Receiver: random back-pressure, plus a long hold when one is requested.
   initial begin
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            holds_done++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Smallest duration that lands in bucket k, for k of 1 or more.
   function automatic logic [63:0] edge_duration(int k);
      logic [255:0] num;
      logic [255:0] den;
      num = 256'd100;
      den = 256'd1;
      for (int j = 0; j < k; j++) begin
         num = num * 256'd7;
         den = den * 256'd5;
      end
      num = (num + den - 256'd1) / den;
      return num[63:0];
   endfunction

   task automatic send_request(input logic mode, input logic [63:0] t0, input logic [63:0] t1,
                               input logic ok, input logic [SEL_W-1:0] sel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sel, t1, t0};
      req_tuser  <= {ok, mode};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_record(input logic [63:0] t0, input logic [63:0] t1, input logic ok);
      send_request(MODE_RECORD, t0, t1, ok, SEL_W'($urandom));
   endtask

   task automatic send_read(input logic [SEL_W-1:0] sel);
      send_request(MODE_READ, rand64(), rand64(), 1'($urandom), sel);
   endtask

   // A counted sample of duration d placed at a random start time.
   task automatic send_duration(input logic [63:0] d);
      logic [63:0] t0;
      t0 = rand64() >> $urandom_range(63);
      if (t0 > TMAX - d) t0 = TMAX - d;
      send_record(t0, t0 + d, 1'b1);
   endtask

   task automatic send_random_item();
      int          pick;
      int          k;
      logic [63:0] a;
      logic [63:0] b;
      pick = $urandom_range(99);
      if (pick < 55) begin
         k = $urandom_range(99);
         if (k < 25)      send_duration(64'($urandom_range(199)));
         else if (k < 55) send_duration(edge_duration($urandom_range(BUCKETS - 1)) +
                                        64'($urandom_range(4)) - 64'd2);
         else if (k < 85) send_duration(rand64() >> $urandom_range(63));
         else             send_record(rand64(), rand64(), 1'b1);
      end else if (pick < 63) begin
         send_record(rand64(), rand64(), 1'b0);
      end else if (pick < 70) begin
         a = rand64();
         b = rand64() >> $urandom_range(63);
         if (a == b) a = b ^ 64'd1;
         if (a > b) send_record(a, b, 1'b1);
         else       send_record(b, a, 1'b1);
      end else begin
         send_read(SEL_W'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests: reset contents, bucket edges, rejects, sum wrap.
      send_idle_pct = 9;
      recv_idle_pct = 63;
      send_read(6'd0);
      send_read(6'd63);
      send_record(64'd0, 64'd0, 1'b1);
      send_record(TMAX, TMAX, 1'b1);
      send_record(64'd1000, 64'd1099, 1'b1);
      send_record(64'd5000, 64'd5100, 1'b1);
      send_record(64'd0, 64'd139, 1'b1);
      send_record(64'd0, 64'd140, 1'b1);
      send_record(64'd0, 64'd195, 1'b1);
      send_record(64'd0, 64'd196, 1'b1);
      send_record(64'd0, 64'd500, 1'b0);
      send_record(64'd501, 64'd500, 1'b1);
      send_record(TMAX, 64'd0, 1'b1);
      send_record(TMAX, 64'd0, 1'b0);
      send_record(64'd0, TMAX, 1'b1);
      send_record(64'd1, TMAX, 1'b1);
      send_duration(edge_duration(62) - 64'd1);
      send_duration(edge_duration(62));
      send_duration(edge_duration(63) - 64'd1);
      send_duration(edge_duration(63));
      send_read(6'd0);
      send_read(6'd1);
      send_read(6'd62);
      send_read(6'd63);

      // The receiver holds off while requests keep coming, so the pipeline
      // fills and the input stalls.
      hold_request = 1;
      repeat (PHASE_ITEMS) send_random_item();

      send_idle_pct = 63;
      recv_idle_pct = 9;
      repeat (PHASE_ITEMS) send_random_item();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (PHASE_ITEMS) send_random_item();
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d counted samples, %0d rejected records and %0d bucket reads;",
               sb.samples_counted, sb.samples_rejected, sb.reads);
      $display("%0d of %0d buckets hit, %0d responses checked, %0d long receiver holds.",
               sb.buckets_reached(), BUCKETS, sb.responses_checked, holds_done);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[latency_log_histogram_stats_unit] OK");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("[latency_log_histogram_stats_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/llhs_pkg.sv
sv/llhs_bucket_calc.sv
sv/llhs_stats.sv
sv/llhs_hist_mem.sv
sv/latency_log_histogram_stats_unit.sv
bench/latency_log_histogram_stats_unit_tb.sv
